FILE: rtl/core/u8v_pkg.sv
// Shared types and helpers for the single-line UTF-8 validator.
// Used by the front classifier, the item queue and the back checker.
package u8v_pkg;

   // Byte class decided without any sequence state
   typedef enum logic [1:0] {
      KIND_ASCII_OK,
      KIND_ASCII_BAD,
      KIND_LEAD,
      KIND_BAD_LEAD
   } kind_type;

   // Classified request passed from front to back
   typedef struct packed {
      logic       byte_present;
      logic       last;
      kind_type   kind;
      logic [7:0] data_byte;
      logic [1:0] lead_rem;
      logic [4:0] lead_bits;
      logic [7:0] second_lo;
      logic [7:0] second_hi;
   } item_type;

   localparam int CP_W = 21;

   localparam logic [7:0] CONT_LO = 8'h80;
   localparam logic [7:0] CONT_HI = 8'hbf;

   // True when a code point may appear on a single line
   function automatic logic single_line_ok(input logic [CP_W-1:0] cp);
      logic ok;
      ok = 1'b1;
      if (cp <= 21'h1f) ok = 1'b0;
      if (cp >= 21'h7f && cp <= 21'h9f) ok = 1'b0;
      if (cp == 21'h2028 || cp == 21'h2029) ok = 1'b0;
      return ok;
   endfunction

endpackage

FILE: rtl/core/u8v_front.sv
// Front stage: accepts requests and classifies each byte into an item.
// Depends on u8v_pkg for the item type and the single-line check.
module u8v_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_present,
   input  logic              req_last,
   output logic              out_valid,
   input  logic              out_ready,
   output u8v_pkg::item_type out_item
);

   logic              f_valid_ff, f_valid_in;
   u8v_pkg::item_type f_item_ff, f_item_in;
   logic              req_fire, push;

   assign push      = f_valid_ff && out_ready;
   assign req_ready = !f_valid_ff || out_ready;
   assign req_fire  = req_valid && req_ready;
   assign out_valid = f_valid_ff;
   assign out_item  = f_item_ff;

   // Classify the incoming byte and pick second-byte bounds for lead bytes
   always_comb begin
      logic [7:0] b;
      b = req_data_byte;
      f_item_in              = '0;
      f_item_in.byte_present = req_byte_present;
      f_item_in.last         = req_last;
      f_item_in.data_byte    = b;
      f_item_in.second_lo    = u8v_pkg::CONT_LO;
      f_item_in.second_hi    = u8v_pkg::CONT_HI;
      f_item_in.kind         = u8v_pkg::KIND_BAD_LEAD;
      if (b <= 8'h7f) begin
         f_item_in.kind = u8v_pkg::single_line_ok({13'd0, b}) ?
                          u8v_pkg::KIND_ASCII_OK : u8v_pkg::KIND_ASCII_BAD;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
         f_item_in.kind      = u8v_pkg::KIND_LEAD;
         f_item_in.lead_rem  = 2'd1;
         f_item_in.lead_bits = b[4:0];
      end else if (b >= 8'he0 && b <= 8'hef) begin
         f_item_in.kind      = u8v_pkg::KIND_LEAD;
         f_item_in.lead_rem  = 2'd2;
         f_item_in.lead_bits = {1'b0, b[3:0]};
         if (b == 8'he0) f_item_in.second_lo = 8'ha0;
         if (b == 8'hed) f_item_in.second_hi = 8'h9f;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
         f_item_in.kind      = u8v_pkg::KIND_LEAD;
         f_item_in.lead_rem  = 2'd3;
         f_item_in.lead_bits = {2'b00, b[2:0]};
         if (b == 8'hf0) f_item_in.second_lo = 8'h90;
         if (b == 8'hf4) f_item_in.second_hi = 8'h8f;
      end
   end

   // Hold the item until the queue takes it
   always_comb begin
      f_valid_in = f_valid_ff;
      if (req_fire) f_valid_in = 1'b1;
      else if (push) f_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      if (req_fire) f_item_ff <= f_item_in;
   end

endmodule

FILE: rtl/core/u8v_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on u8v_pkg for the item type.
module u8v_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  u8v_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output u8v_pkg::item_type pop_item
);

   u8v_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: rtl/core/u8v_back.sv
// Back stage: runs the sequence state over classified items, emits verdicts.
// Depends on u8v_pkg for the item type and the single-line check.
module u8v_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  u8v_pkg::item_type       in_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_valid_res
);

   logic [1:0]               rem_ff, rem_in;
   logic [u8v_pkg::CP_W-1:0] cp_ff, cp_in;
   logic [7:0]               lo_ff, lo_in;
   logic [7:0]               hi_ff, hi_in;
   logic                     exp2_ff, exp2_in;
   logic                     failed_ff, failed_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     res_ff;
   logic                     take;

   // Stall only a final item while an unread verdict sits in the output
   assign in_ready      = !in_item.last || !rsp_valid_ff || rsp_ready;
   assign take          = in_valid && in_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = res_ff;

   // Apply one byte to the sequence state
   always_comb begin
      logic [7:0]               b;
      logic [7:0]               lo, hi;
      logic [u8v_pkg::CP_W-1:0] cp_next;
      logic [1:0]               rem_next;
      b         = in_item.data_byte;
      rem_in    = rem_ff;
      cp_in     = cp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      exp2_in   = exp2_ff;
      failed_in = failed_ff;
      lo        = exp2_ff ? lo_ff : u8v_pkg::CONT_LO;
      hi        = exp2_ff ? hi_ff : u8v_pkg::CONT_HI;
      cp_next   = {cp_ff[u8v_pkg::CP_W-7:0], b[5:0]};
      rem_next  = rem_ff - 2'd1;
      if (in_item.byte_present && !failed_ff) begin
         if (rem_ff == 2'd0) begin
            case (in_item.kind)
               u8v_pkg::KIND_ASCII_OK: begin
               end
               u8v_pkg::KIND_LEAD: begin
                  rem_in  = in_item.lead_rem;
                  cp_in   = {16'd0, in_item.lead_bits};
                  lo_in   = in_item.second_lo;
                  hi_in   = in_item.second_hi;
                  exp2_in = 1'b1;
               end
               default: begin
                  failed_in = 1'b1;
                  cp_in     = '0;
                  exp2_in   = 1'b0;
               end
            endcase
         end else if (b < lo || b > hi) begin
            failed_in = 1'b1;
            rem_in    = 2'd0;
            cp_in     = '0;
            exp2_in   = 1'b0;
         end else begin
            exp2_in = 1'b0;
            rem_in  = rem_next;
            cp_in   = cp_next;
            if (rem_next == 2'd0) begin
               cp_in = '0;
               if (!u8v_pkg::single_line_ok(cp_next)) failed_in = 1'b1;
            end
         end
      end
   end

   // Raise the verdict on a final item, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && in_item.last) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_item.last)) begin
         rem_ff    <= 2'd0;
         cp_ff     <= '0;
         lo_ff     <= u8v_pkg::CONT_LO;
         hi_ff     <= u8v_pkg::CONT_HI;
         exp2_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else if (take) begin
         rem_ff    <= rem_in;
         cp_ff     <= cp_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         exp2_ff   <= exp2_in;
         failed_ff <= failed_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take && in_item.last) res_ff <= !failed_in && (rem_in == 2'd0);
   end

   a_fail_clears_seq: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (rem_ff == 2'd0 && !exp2_ff))
      else $error("failed string still tracks a sequence");

   a_exp2_needs_rem: assert property (@(posedge clock) disable iff (reset)
      exp2_ff |-> (rem_ff != 2'd0))
      else $error("second byte expected with no bytes remaining");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (take && in_item.last) |=> (rem_ff == 2'd0 && !failed_ff && rsp_valid_ff))
      else $error("state not cleared or verdict missing after final item");

endmodule

FILE: rtl/core/utf8_single_line_validator_core.sv
// Single-line UTF-8 validator: one byte per request, one verdict per string.
// Throughput: one request per cycle unless stalled; back checker state update is the only loop.
// Path: a final request's verdict reaches rsp_valid through the front register, loaded at the
// accepting edge, then the queue entry, then the back output register.
// Reset: synchronous, active high; clears the queue, sequence state and pending verdict.
// Depends on u8v_pkg, u8v_front, u8v_queue and u8v_back.
module utf8_single_line_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res
);

   logic              f_valid, f_ready;
   u8v_pkg::item_type f_item;
   logic              q_valid, q_ready;
   u8v_pkg::item_type q_item;

   // Classify requests
   u8v_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .out_valid        (f_valid),
      .out_ready        (f_ready),
      .out_item         (f_item)
   );

   // Decouple front and back
   u8v_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // Check sequences and deliver verdicts
   u8v_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_item       (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for utf8_single_line_validator_core.
// Needs only the core and its sub-blocks; a class-based verdict board predicts every
// string's verdict while plain tasks drive requests under several idle/stall mixes.
module testbench;

   // Byte boundaries of the strict single-line UTF-8 rules
   localparam logic [7:0] ASCII_MAX  = 8'h7f;
   localparam logic [7:0] CTRL_MAX   = 8'h1f;
   localparam logic [7:0] LEAD2_MIN  = 8'hc2;
   localparam logic [7:0] LEAD2_MAX  = 8'hdf;
   localparam logic [7:0] LEAD3_MIN  = 8'he0;
   localparam logic [7:0] LEAD3_MAX  = 8'hef;
   localparam logic [7:0] LEAD3_SURR = 8'hed;
   localparam logic [7:0] LEAD4_MIN  = 8'hf0;
   localparam logic [7:0] LEAD4_MAX  = 8'hf4;
   localparam logic [7:0] CONT_MIN   = 8'h80;
   localparam logic [7:0] CONT_MAX   = 8'hbf;
   localparam logic [7:0] E0_SECOND_MIN = 8'ha0;
   localparam logic [7:0] ED_SECOND_MAX = 8'h9f;
   localparam logic [7:0] F0_SECOND_MIN = 8'h90;
   localparam logic [7:0] F4_SECOND_MAX = 8'h8f;
   localparam logic [20:0] C1_LO     = 21'h7f;
   localparam logic [20:0] C1_HI     = 21'h9f;
   localparam logic [20:0] LINE_SEP  = 21'h2028;
   localparam logic [20:0] PARA_SEP  = 21'h2029;

   localparam int LATENCY     = 2;
   localparam int DRAIN_GAP   = 4 * LATENCY;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 100;

   // Verdict board: tracks decoder state and queues the expected verdict per string
   class verdict_board;
      logic [1:0]  rem;
      logic [20:0] cp;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic        second;
      logic        failed;
      logic        verdict_q[$];
      int          errors;
      int          requests;
      int          verdicts;
      int          passes;

      function new();
         errors = 0;
         requests = 0;
         verdicts = 0;
         passes = 0;
         clear();
      endfunction

      function void clear();
         rem = 2'd0;
         cp = '0;
         lo = CONT_MIN;
         hi = CONT_MAX;
         second = 1'b0;
         failed = 1'b0;
      endfunction

      function bit line_ok(logic [20:0] c);
         if (c <= 21'(CTRL_MAX)) return 1'b0;
         if (c >= C1_LO && c <= C1_HI) return 1'b0;
         if (c == LINE_SEP || c == PARA_SEP) return 1'b0;
         return 1'b1;
      endfunction

      function void fail_string();
         failed = 1'b1;
         rem = 2'd0;
         second = 1'b0;
         cp = '0;
      endfunction

      function void open_seq(logic [1:0] r, logic [20:0] bits, logic [7:0] l, logic [7:0] h);
         rem = r;
         cp = bits;
         lo = l;
         hi = h;
         second = 1'b1;
      endfunction

      function void decode_byte(logic [7:0] b);
         logic [7:0] l;
         logic [7:0] h;
         if (failed) return;
         if (rem == 2'd0) begin
            if (b <= ASCII_MAX) begin
               if (!line_ok(21'(b))) fail_string();
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               open_seq(2'd1, 21'(b & 8'h1f), CONT_MIN, CONT_MAX);
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               if (b == LEAD3_MIN) open_seq(2'd2, 21'(b & 8'h0f), E0_SECOND_MIN, CONT_MAX);
               else if (b == LEAD3_SURR) open_seq(2'd2, 21'(b & 8'h0f), CONT_MIN, ED_SECOND_MAX);
               else open_seq(2'd2, 21'(b & 8'h0f), CONT_MIN, CONT_MAX);
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               if (b == LEAD4_MIN) open_seq(2'd3, 21'(b & 8'h07), F0_SECOND_MIN, CONT_MAX);
               else if (b == LEAD4_MAX) open_seq(2'd3, 21'(b & 8'h07), CONT_MIN, F4_SECOND_MAX);
               else open_seq(2'd3, 21'(b & 8'h07), CONT_MIN, CONT_MAX);
            end else begin
               fail_string();
            end
            return;
         end
         l = second ? lo : CONT_MIN;
         h = second ? hi : CONT_MAX;
         if (b < l || b > h) begin
            fail_string();
            return;
         end
         cp = {cp[14:0], b[5:0]};
         second = 1'b0;
         rem = rem - 2'd1;
         if (rem == 2'd0) begin
            if (!line_ok(cp)) fail_string();
            else cp = '0;
         end
      endfunction

      // Note one accepted request
      function void note_request(logic [7:0] b, logic present, logic last);
         logic v;
         requests++;
         if (present) decode_byte(b);
         if (last) begin
            v = (!failed && rem == 2'd0);
            verdict_q.insert(verdict_q.size(), v);
            if (v) passes++;
            clear();
         end
      endfunction

      // Compare one accepted verdict with the oldest expectation
      function void check_verdict(logic actual);
         logic want;
         verdicts++;
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, actual %b", $time, actual);
            errors++;
            return;
         end
         want = verdict_q.pop_front();
         if (actual !== want)  begin
            $display("%0t: verdict mismatch, expected %b, actual %b", $time, want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_byte_present = 1'b0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_valid_res;

   verdict_board board;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int noop_pct = 0;
   int items_sent = 0;
   int strings_sent = 0;
   int cycles = 0;

   utf8_single_line_validator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitor both handshakes; check responses before noting the new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_verdict(rsp_valid_res);
         if (req_valid && req_ready) board.note_request(req_data_byte, req_byte_present, req_last);
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d verdicts outstanding", $time, board.pending());
         $display("FAIL utf8_single_line_validator_core");
         $finish;
      end
   end

   // Drive one request, idling first at random; returns at the falling edge after acceptance
   task automatic send_item(logic [7:0] b, logic present, logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_byte_present <= present;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Send one string, ending either on its final byte or with a separate end marker
   task automatic send_string(logic [7:0] bytes[$], bit end_marker);
      for (int i = 0; i < bytes.size(); i++) begin
         if ($urandom_range(0, 99) < noop_pct) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(bytes[i], 1'b1, (i == bytes.size() - 1) && !end_marker);
      end
      if (end_marker || bytes.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
      strings_sent++;
   endtask

   // Hold off new requests until every verdict has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   // Append one byte to the end of a string under construction
   function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
      q.insert(q.size(), b);
   endfunction

   function automatic void push_cp(logic [20:0] c, ref logic [7:0] q[$]);
      if (c < 21'h80) begin
         put_byte(q, c[7:0]);
      end else if (c < 21'h800) begin
         put_byte(q, {3'b110, c[10:6]});
         put_byte(q, {2'b10, c[5:0]});
      end else if (c < 21'h10000) begin
         put_byte(q, {4'b1110, c[15:12]});
         put_byte(q, {2'b10, c[11:6]});
         put_byte(q, {2'b10, c[5:0]});
      end else begin
         put_byte(q, {5'b11110, c[20:18]});
         put_byte(q, {2'b10, c[17:12]});
         put_byte(q, {2'b10, c[11:6]});
         put_byte(q, {2'b10, c[5:0]});
      end
   endfunction

   // Append one random symbol: mostly well-formed code points, some broken forms
   function automatic void push_symbol(ref logic [7:0] q[$]);
      int r;
      logic [20:0] edges[12];
      edges = '{21'h2028, 21'h2029, 21'hd800, 21'hdfff, 21'h800, 21'hffff,
                21'h10ffff, 21'h10000, 21'h9f, 21'ha0, 21'h7ff, 21'h20};
      r = $urandom_range(0, 99);
      if (r < 38) push_cp(21'($urandom_range(8'h20, 8'h7e)), q);
      else if (r < 43) push_cp(($urandom_range(0, 1) != 0) ? 21'h7f
                                 : 21'($urandom_range(0, 8'h1f)), q);
      else if (r < 58) push_cp(21'($urandom_range(21'h80, 21'h7ff)), q);
      else if (r < 74) push_cp(21'($urandom_range(21'h800, 21'hffff)), q);
      else if (r < 80) push_cp(edges[$urandom_range(0, 11)], q);
      else if (r < 92) push_cp(21'($urandom_range(21'h10000, 21'h10ffff)), q);
      else if (r < 94) begin
         // overlong three-byte form
         put_byte(q, LEAD3_MIN);
         put_byte(q, 8'($urandom_range(CONT_MIN, 8'h9f)));
         put_byte(q, 8'($urandom_range(CONT_MIN, CONT_MAX)));
      end else if (r < 96) begin
         // four-byte form that may be overlong or out of range
         put_byte(q, ($urandom_range(0, 1) != 0) ? LEAD4_MIN : LEAD4_MAX);
         put_byte(q, 8'($urandom_range(CONT_MIN, CONT_MAX)));
         put_byte(q, 8'($urandom_range(CONT_MIN, CONT_MAX)));
         put_byte(q, 8'($urandom_range(CONT_MIN, CONT_MAX)));
      end else begin
         put_byte(q, 8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_random_string();
      logic [7:0] q[$];
      int n;
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) push_symbol(q);
      // drop the final byte now and then, which may truncate a sequence
      if (q.size() > 1 && $urandom_range(0, 99) < 8) void'(q.pop_back());
      send_string(q, $urandom_range(0, 99) < 30);
   endtask

   task automatic directed();
      logic [7:0] d[$];
      d = {};                                 send_string(d, 1'b1);  // empty string
      d = {8'h20, 8'h7e};                     send_string(d, 1'b0);
      d = {8'h00};                            send_string(d, 1'b0);
      d = {8'h7f};                            send_string(d, 1'b0);
      d = {8'hc2, 8'ha0};                     send_string(d, 1'b0);
      d = {8'hc2, 8'h80};                     send_string(d, 1'b0);  // C1 control
      d = {8'hc1, 8'hbf};                     send_string(d, 1'b0);  // bad lead
      d = {8'he0, 8'ha0, 8'h80};              send_string(d, 1'b0);
      d = {8'hed, 8'ha0, 8'h80};              send_string(d, 1'b0);  // surrogate
      d = {8'he2, 8'h80, 8'ha8};              send_string(d, 1'b0);  // line separator
      // idle item at the start of a string changes nothing
      send_item(8'hff, 1'b0, 1'b0);
      d = {8'hf4, 8'h8f, 8'hbf, 8'hbf};       send_string(d, 1'b1);
      d = {8'hf0, 8'h8f};                     send_string(d, 1'b0);  // overlong
      d = {8'hdf};                            send_string(d, 1'b0);  // truncated
      d = {8'hff, 8'h41};                     send_string(d, 1'b0);  // bytes after failure
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < 4; ph++) begin
         int start;
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         noop_pct = 0;
         start = items_sent;
         if (ph == 0) directed();
         noop_pct = 5;
         while (items_sent - start < PHASE_ITEMS) send_random_string();
         drain();
      end

      recv_stall_pct = 0;
      drain();
      $display("Ran %0d strings in %0d requests over four idle/stall mixes;",
               strings_sent, board.requests);
      $display("checked %0d verdicts, %0d of them valid, in %0d cycles.",
               board.verdicts, board.passes, cycles);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS utf8_single_line_validator_core");
      end else begin
         $display("FAIL utf8_single_line_validator_core");
      end
      $finish;
   end

endmodule
